// ----- rtl/bfg_pkg.sv -----
package bfg_pkg;

	// field and register widths
	localparam int MV_W      = 14;
	localparam int PCT_W     = 7;
	localparam int TICK_W    = 3;
	localparam int DIVR_W    = 7;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 3;

	localparam int ADC_BITS_DEF = 10;
	localparam int WINDOW_DEF   = 5;

	// converter scaling
	localparam int ADC_REF_MV = 3600;
	localparam int ADC_MV_W   = 12;
	localparam int MV_SCALE   = 100;

	// shared divider
	localparam int NUM_W  = 21;
	localparam int ITER_W = 4;

	// charge curves
	localparam int CURVE_POINTS = 11;
	localparam int STEP         = 100 / (CURVE_POINTS - 1);
	localparam int SEG_W        = $clog2(CURVE_POINTS);
	localparam int PCT_ITERS    = $clog2(STEP + 1);
	localparam int AVG_ITERS    = MV_W;
	localparam int DONE_PERCENT = 98;

	typedef logic [MV_W-1:0] mv_t;

	localparam mv_t MV_MAX = '1;
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

	localparam mv_t CURVE_DIS [CURVE_POINTS] = '{
		14'd3150, 14'd3500, 14'd3630, 14'd3720, 14'd3770, 14'd3810,
		14'd3860, 14'd3920, 14'd3980, 14'd4040, 14'd4160
	};
	localparam mv_t CURVE_CHG [CURVE_POINTS] = '{
		14'd3257, 14'd3677, 14'd3757, 14'd3850, 14'd3943, 14'd4002,
		14'd4039, 14'd4071, 14'd4103, 14'd4150, 14'd4200
	};

	localparam mv_t CUTOFF_MV = CURVE_DIS[0];

	// lowest voltage whose charge-curve percent reaches the done level
	localparam int DONE_SEG  = DONE_PERCENT / STEP;
	localparam int DONE_REM  = DONE_PERCENT - DONE_SEG * STEP;
	localparam int DONE_SPAN = int'(CURVE_CHG[DONE_SEG + 1]) - int'(CURVE_CHG[DONE_SEG]);
	localparam mv_t DONE_MV  = mv_t'(int'(CURVE_CHG[DONE_SEG])
		+ (DONE_REM * DONE_SPAN + STEP - 1) / STEP);

	// register reset values
	localparam logic [TICK_W-1:0] DEB_TICKS_RST  = 3'd3;
	localparam logic [TICK_W-1:0] SHUT_TICKS_RST = 3'd5;
	localparam logic [TICK_W-1:0] CHG_TICKS_RST  = 3'd3;
	localparam mv_t               PRESENT_RST    = 14'd2000;
	localparam mv_t               MAX_MV_RST     = 14'd4350;
	localparam logic [DIVR_W-1:0] DIVIDER_RST    = 7'd40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE,
		REG_SHUT_CONFIRM,
		REG_CHG_CONFIRM,
		REG_PRESENT,
		REG_MAX_MV,
		REG_DIVIDER
	} reg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_NO_BATT,
		STAT_DISCHG,
		STAT_CHARGING,
		STAT_DONE
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_VDIV_GO,
		S_VDIV,
		S_HIST,
		S_SUM,
		S_ADIV_GO,
		S_ADIV,
		S_LOW,
		S_SEG,
		S_PDIV_GO,
		S_PDIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		mv_t               den;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic fill;
		logic wr;
		logic acc;
	} hist_ctl_t;

	function automatic mv_t curve_pt(input logic chg, input logic [SEG_W-1:0] idx);
		mv_t pt;
		if (int'(idx) < CURVE_POINTS) begin
			pt = chg ? CURVE_CHG[idx] : CURVE_DIS[idx];
		end else begin
			pt = chg ? CURVE_CHG[CURVE_POINTS-1] : CURVE_DIS[CURVE_POINTS-1];
		end
		return pt;
	endfunction

	// first segment whose upper point is at or above mv
	function automatic logic [SEG_W-1:0] seg_find(input logic chg, input mv_t mv);
		logic [SEG_W-1:0] seg;
		seg = SEG_W'(CURVE_POINTS - 2);
		for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
			if (mv <= curve_pt(chg, SEG_W'(i + 1))) begin
				seg = SEG_W'(i);
			end
		end
		return seg;
	endfunction

endpackage

// ----- rtl/bfg_in_if.sv -----
interface bfg_in_if #(
	parameter int ADC_BITS = bfg_pkg::ADC_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;
	logic                power_raw;

	modport source (output valid, output adc_sample, output power_raw, input ready);
	modport sink (input valid, input adc_sample, input power_raw, output ready);
endinterface

// ----- rtl/bfg_out_if.sv -----
interface bfg_out_if ();
	logic                         valid;
	logic                         ready;
	logic [bfg_pkg::MV_W-1:0]     filtered_mv;
	logic [bfg_pkg::PCT_W-1:0]    percent;
	logic                         shutdown_req;
	logic                         power_stable;
	logic [bfg_pkg::STAT_W-1:0]   status_code;

	modport source (output valid, output filtered_mv, output percent, output shutdown_req,
		output power_stable, output status_code, input ready);
	modport sink (input valid, input filtered_mv, input percent, input shutdown_req,
		input power_stable, input status_code, output ready);
endinterface

// ----- rtl/bfg_div.sv -----
module bfg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bfg_pkg::div_req_t  req,
	output logic               busy,
	output logic               done,
	output bfg_pkg::mv_t       quo
);

	logic [bfg_pkg::NUM_W-1:0]  rem_q;
	logic [bfg_pkg::NUM_W-1:0]  den_q;
	bfg_pkg::mv_t               quo_q;
	logic [bfg_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       take;

	// restoring step: one quotient bit per cycle
	assign take = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - bfg_pkg::ITER_W'(1);
				if (cnt_q == bfg_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= bfg_pkg::NUM_W'(req.den) << (req.iters - bfg_pkg::ITER_W'(1));
			quo_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[bfg_pkg::MV_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/bfg_hist.sv -----
module bfg_hist #(
	parameter int WINDOW = bfg_pkg::WINDOW_DEF,
	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
	localparam int CNT_W = $clog2(WINDOW + 1),
	localparam int SUM_W = bfg_pkg::MV_W + CNT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfg_pkg::hist_ctl_t ctl,
	input  bfg_pkg::mv_t       wdata,
	output logic [CNT_W-1:0]   count,
	output logic [SUM_W-1:0]   sum,
	output logic               acc_done
);

	bfg_pkg::mv_t     mem_q [WINDOW];
	logic [POS_W-1:0] pos_q;
	logic             full_q;
	logic [CNT_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic             wrap;

	assign wrap = pos_q == POS_W'(WINDOW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (ctl.fill) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else if (ctl.wr) begin
				pos_q <= wrap ? '0 : pos_q + POS_W'(1);
				if (wrap) begin
					full_q <= 1'b1;
				end
				idx_q <= '0;
			end else if (ctl.acc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill) begin
			for (int i = 0; i < WINDOW; i++) begin
				mem_q[i] <= wdata;
			end
		end else if (ctl.wr) begin
			mem_q[pos_q] <= wdata;
		end
		if (ctl.wr) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + SUM_W'(mem_q[idx_q[POS_W-1:0]]);
		end
	end

	assign count    = full_q ? CNT_W'(WINDOW) : CNT_W'(pos_q);
	assign acc_done = idx_q == count;
	assign sum      = sum_q;

endmodule

// ----- rtl/battery_fuel_gauge.sv -----
// voltage-based battery fuel gauge
// sample channel (valid/ready): one transaction per measurement tick, carrying
//   the raw converter reading adc_sample and the undebounced power_raw level
// result channel (valid/ready): one transaction per sample with the filtered
//   voltage, percent, shutdown request, debounced power state and status code
// config port: cfg_wen writes cfg_data into register cfg_index;
//   write only while no sample is in flight; unknown indexes are ignored
// timing: one sample at a time, sample.ready is high only while idle; the
//   shared restoring divider works out the millivolt quotient, then the
//   history is summed, then the divider gives the average quotient and the
//   curve interpolation
// a saturated reading skips the millivolt divide, a power change skips the
//   sum and average, and a curve end or flat segment skips the interpolation
// reset: registers take their defaults, history and counters clear, no
//   result is pending
// stall: the result sits in an output register, so the next sample is taken
//   and worked on while the receiver holds off; only a finished second result
//   waits for the register to free up
module battery_fuel_gauge #(
	parameter int WINDOW   = bfg_pkg::WINDOW_DEF,
	parameter int ADC_BITS = bfg_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bfg_in_if.sink                          sample,
	bfg_out_if.source                       result,
	input  logic                            cfg_wen,
	input  logic [bfg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfg_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = bfg_pkg::MV_W + CNT_W;
	localparam int PROD_W = ADC_BITS + bfg_pkg::ADC_MV_W;

	// sequencer
	bfg_pkg::state_t state_q;
	bfg_pkg::state_t state_n;

	// configuration registers
	logic [bfg_pkg::TICK_W-1:0] deb_ticks_q;
	logic [bfg_pkg::TICK_W-1:0] shut_ticks_q;
	logic [bfg_pkg::TICK_W-1:0] chg_ticks_q;
	bfg_pkg::mv_t               present_q;
	bfg_pkg::mv_t               max_mv_q;
	logic [bfg_pkg::DIVR_W-1:0] divider_q;

	// tracking state carried between samples
	logic                       raw_prev_q;
	logic [bfg_pkg::TICK_W-1:0] deb_cnt_q;
	logic                       pstate_q;
	logic                       pseen_q;
	logic [bfg_pkg::TICK_W-1:0] lv_cnt_q;
	logic [bfg_pkg::TICK_W-1:0] chg_cnt_q;

	// working registers of the current sample
	logic [bfg_pkg::ADC_MV_W-1:0] adc_mv_q;
	logic [bfg_pkg::NUM_W-1:0]    num_q;
	bfg_pkg::mv_t                 vbat_q;
	bfg_pkg::mv_t                 filt_q;
	bfg_pkg::mv_t                 clamp_q;
	bfg_pkg::mv_t                 lo_q;
	bfg_pkg::mv_t                 span_q;
	logic [bfg_pkg::SEG_W-1:0]    seg_q;
	logic [bfg_pkg::PCT_W-1:0]    pct_q;
	logic                         shut_q;
	bfg_pkg::status_t             status_q;

	// output register
	logic                         out_valid_q;
	bfg_pkg::mv_t                 out_filt_q;
	logic [bfg_pkg::PCT_W-1:0]    out_pct_q;
	logic                         out_shut_q;
	logic                         out_pwr_q;
	bfg_pkg::status_t             out_stat_q;

	// shared divider and history
	bfg_pkg::div_req_t  div_req;
	logic               div_busy;
	logic               div_done;
	bfg_pkg::mv_t       div_quo;
	bfg_pkg::hist_ctl_t hist_ctl;
	logic [CNT_W-1:0]   hist_count;
	logic [SUM_W-1:0]   hist_sum;
	logic               hist_done;

	logic                       accept;
	logic                       out_load;
	logic [bfg_pkg::TICK_W-1:0] deb_cnt_n;
	logic [PROD_W-1:0]          adc_prod;
	logic                       vsat;
	logic                       low_v;
	logic [bfg_pkg::TICK_W-1:0] lv_cnt_n;
	logic                       shut_c;
	bfg_pkg::mv_t               clamp_a;
	bfg_pkg::mv_t               clamp_c;
	logic [bfg_pkg::TICK_W-1:0] chg_cnt_n;
	bfg_pkg::status_t           status_c;
	logic [bfg_pkg::SEG_W-1:0]  seg_c;
	bfg_pkg::mv_t               seg_lo;
	bfg_pkg::mv_t               seg_hi;
	logic                       at_lo;
	logic                       at_hi;
	logic                       flat;
	logic [bfg_pkg::NUM_W-1:0]  pnum;

	bfg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	bfg_hist #(
		.WINDOW (WINDOW)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hist_ctl),
		.wdata    (vbat_q),
		.count    (hist_count),
		.sum      (hist_sum),
		.acc_done (hist_done)
	);

	assign sample.ready = state_q == bfg_pkg::S_IDLE;
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == bfg_pkg::S_DONE) && (!out_valid_q || result.ready);

	// debounce: count equal raw levels, restart on a change
	always_comb begin
		if (sample.power_raw != raw_prev_q) begin
			deb_cnt_n = '0;
		end else if (deb_cnt_q < deb_ticks_q) begin
			deb_cnt_n = deb_cnt_q + bfg_pkg::TICK_W'(1);
		end else begin
			deb_cnt_n = deb_cnt_q;
		end
	end

	// converter millivolts, then overflow check of the divider quotient
	assign adc_prod = PROD_W'(sample.adc_sample) * PROD_W'(bfg_pkg::ADC_REF_MV);
	assign vsat     = (divider_q == '0)
		|| (num_q >= (bfg_pkg::NUM_W'(divider_q) << bfg_pkg::MV_W));

	// low-voltage confirmation, clamping and status
	always_comb begin
		low_v    = !pstate_q && (filt_q < bfg_pkg::CUTOFF_MV);
		lv_cnt_n = '0;
		shut_c   = 1'b0;
		clamp_a  = (filt_q > max_mv_q) ? max_mv_q : filt_q;
		if (low_v) begin
			lv_cnt_n = (lv_cnt_q < shut_ticks_q) ? lv_cnt_q + bfg_pkg::TICK_W'(1) : lv_cnt_q;
			shut_c   = lv_cnt_n >= shut_ticks_q;
			clamp_a  = filt_q;
		end
		clamp_c = (clamp_a < bfg_pkg::CUTOFF_MV) ? bfg_pkg::CUTOFF_MV : clamp_a;

		chg_cnt_n = '0;
		status_c  = bfg_pkg::STAT_NO_BATT;
		if (filt_q >= present_q) begin
			status_c = bfg_pkg::STAT_DISCHG;
			if (pstate_q) begin
				// charging only once the count had already reached its limit
				if (chg_cnt_q < chg_ticks_q) begin
					chg_cnt_n = chg_cnt_q + bfg_pkg::TICK_W'(1);
				end else begin
					chg_cnt_n = chg_cnt_q;
					status_c  = bfg_pkg::STAT_CHARGING;
				end
				if (filt_q >= bfg_pkg::DONE_MV) begin
					status_c = bfg_pkg::STAT_DONE;
				end
			end
		end
	end

	// curve segment of the clamped voltage; charge curve while powered
	assign seg_c  = bfg_pkg::seg_find(pstate_q, clamp_q);
	assign seg_lo = bfg_pkg::curve_pt(pstate_q, seg_c);
	assign seg_hi = bfg_pkg::curve_pt(pstate_q, seg_c + bfg_pkg::SEG_W'(1));
	assign at_lo  = clamp_q <= bfg_pkg::curve_pt(pstate_q, '0);
	assign at_hi  = clamp_q >= bfg_pkg::curve_pt(pstate_q,
		bfg_pkg::SEG_W'(bfg_pkg::CURVE_POINTS - 1));
	assign flat   = seg_hi == seg_lo;
	assign pnum   = bfg_pkg::NUM_W'(clamp_q - lo_q) * bfg_pkg::NUM_W'(bfg_pkg::STEP);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			bfg_pkg::S_IDLE: begin
				if (accept) begin
					state_n = bfg_pkg::S_SCALE;
				end
			end
			bfg_pkg::S_SCALE:   state_n = bfg_pkg::S_VDIV_GO;
			bfg_pkg::S_VDIV_GO: state_n = vsat ? bfg_pkg::S_HIST : bfg_pkg::S_VDIV;
			bfg_pkg::S_VDIV: begin
				if (div_done) begin
					state_n = bfg_pkg::S_HIST;
				end
			end
			bfg_pkg::S_HIST: begin
				state_n = (pstate_q != pseen_q) ? bfg_pkg::S_LOW : bfg_pkg::S_SUM;
			end
			bfg_pkg::S_SUM: begin
				if (hist_done) begin
					state_n = bfg_pkg::S_ADIV_GO;
				end
			end
			bfg_pkg::S_ADIV_GO: state_n = bfg_pkg::S_ADIV;
			bfg_pkg::S_ADIV: begin
				if (div_done) begin
					state_n = bfg_pkg::S_LOW;
				end
			end
			bfg_pkg::S_LOW: state_n = bfg_pkg::S_SEG;
			bfg_pkg::S_SEG: begin
				state_n = (at_lo || at_hi || flat) ? bfg_pkg::S_DONE : bfg_pkg::S_PDIV_GO;
			end
			bfg_pkg::S_PDIV_GO: state_n = bfg_pkg::S_PDIV;
			bfg_pkg::S_PDIV: begin
				if (div_done) begin
					state_n = bfg_pkg::S_DONE;
				end
			end
			bfg_pkg::S_DONE: begin
				if (out_load) begin
					state_n = bfg_pkg::S_IDLE;
				end
			end
			default: state_n = bfg_pkg::S_IDLE;
		endcase
	end

	// divider requests and history control per state
	always_comb begin
		div_req  = '0;
		hist_ctl = '0;
		case (state_q)
			bfg_pkg::S_VDIV_GO: begin
				div_req.start = !vsat;
				div_req.num   = num_q;
				div_req.den   = bfg_pkg::MV_W'(divider_q);
				div_req.iters = bfg_pkg::ITER_W'(bfg_pkg::AVG_ITERS);
			end
			bfg_pkg::S_HIST: begin
				hist_ctl.fill = pstate_q != pseen_q;
				hist_ctl.wr   = pstate_q == pseen_q;
			end
			bfg_pkg::S_SUM: begin
				hist_ctl.acc = !hist_done;
			end
			bfg_pkg::S_ADIV_GO: begin
				div_req.start = 1'b1;
				div_req.num   = bfg_pkg::NUM_W'(hist_sum);
				div_req.den   = bfg_pkg::MV_W'(hist_count);
				div_req.iters = bfg_pkg::ITER_W'(bfg_pkg::AVG_ITERS);
			end
			bfg_pkg::S_PDIV_GO: begin
				div_req.start = 1'b1;
				div_req.num   = pnum;
				div_req.den   = span_q;
				div_req.iters = bfg_pkg::ITER_W'(bfg_pkg::PCT_ITERS);
			end
			default: begin
				div_req  = '0;
				hist_ctl = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bfg_pkg::S_IDLE;
			deb_ticks_q  <= bfg_pkg::DEB_TICKS_RST;
			shut_ticks_q <= bfg_pkg::SHUT_TICKS_RST;
			chg_ticks_q  <= bfg_pkg::CHG_TICKS_RST;
			present_q    <= bfg_pkg::PRESENT_RST;
			max_mv_q     <= bfg_pkg::MAX_MV_RST;
			divider_q    <= bfg_pkg::DIVIDER_RST;
			raw_prev_q   <= 1'b0;
			deb_cnt_q    <= '0;
			pstate_q     <= 1'b0;
			pseen_q      <= 1'b0;
			lv_cnt_q     <= '0;
			chg_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;

			if (cfg_wen) begin
				case (bfg_pkg::reg_idx_t'(cfg_index))
					bfg_pkg::REG_DEBOUNCE:     deb_ticks_q  <= cfg_data[bfg_pkg::TICK_W-1:0];
					bfg_pkg::REG_SHUT_CONFIRM: shut_ticks_q <= cfg_data[bfg_pkg::TICK_W-1:0];
					bfg_pkg::REG_CHG_CONFIRM:  chg_ticks_q  <= cfg_data[bfg_pkg::TICK_W-1:0];
					bfg_pkg::REG_PRESENT:      present_q    <= cfg_data[bfg_pkg::MV_W-1:0];
					bfg_pkg::REG_MAX_MV:       max_mv_q     <= cfg_data[bfg_pkg::MV_W-1:0];
					bfg_pkg::REG_DIVIDER:      divider_q    <= cfg_data[bfg_pkg::DIVR_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				raw_prev_q <= sample.power_raw;
				deb_cnt_q  <= deb_cnt_n;
				if (deb_cnt_n >= deb_ticks_q) begin
					pstate_q <= sample.power_raw;
				end
			end

			// power state change restarts the average
			if (hist_ctl.fill) begin
				pseen_q <= pstate_q;
			end

			if (state_q == bfg_pkg::S_LOW) begin
				lv_cnt_q  <= lv_cnt_n;
				chg_cnt_q <= chg_cnt_n;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			adc_mv_q <= bfg_pkg::ADC_MV_W'(adc_prod >> ADC_BITS);
		end
		if (state_q == bfg_pkg::S_SCALE) begin
			num_q <= bfg_pkg::NUM_W'(adc_mv_q) * bfg_pkg::NUM_W'(bfg_pkg::MV_SCALE);
		end
		if ((state_q == bfg_pkg::S_VDIV_GO) && vsat) begin
			vbat_q <= bfg_pkg::MV_MAX;
		end
		if ((state_q == bfg_pkg::S_VDIV) && div_done) begin
			vbat_q <= div_quo;
		end
		if (hist_ctl.fill) begin
			filt_q <= vbat_q;
		end
		if ((state_q == bfg_pkg::S_ADIV) && div_done) begin
			filt_q <= div_quo;
		end
		if (state_q == bfg_pkg::S_LOW) begin
			clamp_q  <= clamp_c;
			shut_q   <= shut_c;
			status_q <= status_c;
		end
		if (state_q == bfg_pkg::S_SEG) begin
			seg_q  <= seg_c;
			lo_q   <= seg_lo;
			span_q <= seg_hi - seg_lo;
			if (at_lo) begin
				pct_q <= '0;
			end else if (at_hi) begin
				pct_q <= bfg_pkg::PCT_FULL;
			end else begin
				pct_q <= bfg_pkg::PCT_W'(seg_c) * bfg_pkg::PCT_W'(bfg_pkg::STEP);
			end
		end
		if ((state_q == bfg_pkg::S_PDIV) && div_done) begin
			pct_q <= bfg_pkg::PCT_W'(seg_q) * bfg_pkg::PCT_W'(bfg_pkg::STEP)
				+ bfg_pkg::PCT_W'(div_quo);
		end
		if (out_load) begin
			out_filt_q <= filt_q;
			out_pct_q  <= pct_q;
			out_shut_q <= shut_q;
			out_pwr_q  <= pstate_q;
			out_stat_q <= status_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.filtered_mv  = out_filt_q;
	assign result.percent      = out_pct_q;
	assign result.shutdown_req = out_shut_q;
	assign result.power_stable = out_pwr_q;
	assign result.status_code  = out_stat_q;

	// the divider only runs while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == bfg_pkg::S_VDIV || state_q == bfg_pkg::S_ADIV
			|| state_q == bfg_pkg::S_PDIV))
		else $error("divider busy outside a divide wait state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("sample taken while previous one still in progress");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result.valid && (result.percent <= bfg_pkg::PCT_FULL))
		else $error("loaded result not valid or percent out of range");

	a_shut_unpowered: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.shutdown_req && result.power_stable))
		else $error("shutdown requested with external power present");

	a_done_powered: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status_code == bfg_pkg::STAT_DONE)) |-> result.power_stable)
		else $error("charge done reported without external power");

endmodule
